/* sv/plcsv_pkg.sv */
// Shared types and constants for the split-valve PID level controller.
package plcsv_pkg;

  // Field widths of the channels and registers
  localparam int SETPOINT_W = 10;
  localparam int LEVEL_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int PERIOD_W   = 8;
  localparam int LIMIT_W    = 16;
  localparam int DUTY_W     = 10;
  localparam int CMD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: error, derivative difference, clamped integral, product
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int INTEG_W = 18;
  localparam int MUL_W   = 18;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ISUM_W  = 27;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VLIM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DLIM   = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0]   KP_RST     = 16'd1280;
  localparam logic [GAIN_W-1:0]   KI_RST     = 16'd128;
  localparam logic [GAIN_W-1:0]   KD_RST     = 16'd102;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd128;
  localparam logic [LIMIT_W-1:0]  ILIM_RST   = 16'd2560;
  localparam logic [LIMIT_W-1:0]  VLIM_RST   = 16'd1000;
  localparam logic [DUTY_W-1:0]   DLIM_RST   = 10'd100;

  // Divide by ten: exact as (x * 6554) >> 16 for x below 10240; any larger
  // magnitude gives a quotient above every possible duty limit
  localparam int DIV10_IN_W  = 14;
  localparam int DIV10_MUL_W = 13;
  localparam int DIV10_SHIFT = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL    = 13'd6554;
  localparam logic [DIV10_IN_W-1:0]  DUTY_SAT_MAG = 14'd10240;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INTEG,
    S_PROP,
    S_IGAIN,
    S_DGAIN,
    S_SUM,
    S_MAG,
    S_OUT
  } plcsv_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul_integ;
    logic mul_prop;
    logic mul_igain;
    logic mul_dgain;
    logic sum;
    logic mag;
    logic out_load;
  } plcsv_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic run;
    logic out_free;
  } plcsv_status_t;

endpackage

/* sv/plcsv_ifs.sv */
// Valid/ready channel interfaces for control ticks and valve results.
interface plcsv_in_if;
  logic                            valid;
  logic                            ready;
  logic [plcsv_pkg::SETPOINT_W-1:0] setpoint;
  logic [plcsv_pkg::LEVEL_W-1:0]    level_meas;
  logic                            start_request;
  logic                            stop_request;

  modport source (output valid, output setpoint, output level_meas,
                  output start_request, output stop_request, input ready);
  modport sink   (input valid, input setpoint, input level_meas,
                  input start_request, input stop_request, output ready);
endinterface

interface plcsv_out_if;
  logic                         valid;
  logic                         ready;
  logic [plcsv_pkg::CMD_W-1:0]  fill_command;
  logic [plcsv_pkg::CMD_W-1:0]  discharge_command;
  logic [plcsv_pkg::DUTY_W-1:0] fill_duty;
  logic [plcsv_pkg::DUTY_W-1:0] discharge_duty;
  logic                         running;

  modport source (output valid, output fill_command, output discharge_command,
                  output fill_duty, output discharge_duty, output running,
                  input ready);
  modport sink   (input valid, input fill_command, input discharge_command,
                  input fill_duty, input discharge_duty, input running,
                  output ready);
endinterface

/* sv/plcsv_ctrl.sv */
// Sequencer for the PID tick: steps the shared multiplier and accumulator.
module plcsv_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  plcsv_pkg::plcsv_status_t status,
  output plcsv_pkg::plcsv_cmd_t    cmd
);

  plcsv_pkg::plcsv_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plcsv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plcsv_pkg::S_IDLE: begin
        if (in_valid) state_nxt = plcsv_pkg::S_INTEG;
      end
      plcsv_pkg::S_INTEG: begin
        // stopped ticks skip the arithmetic and report zeros
        state_nxt = status.run ? plcsv_pkg::S_PROP : plcsv_pkg::S_OUT;
      end
      plcsv_pkg::S_PROP:  state_nxt = plcsv_pkg::S_IGAIN;
      plcsv_pkg::S_IGAIN: state_nxt = plcsv_pkg::S_DGAIN;
      plcsv_pkg::S_DGAIN: state_nxt = plcsv_pkg::S_SUM;
      plcsv_pkg::S_SUM:   state_nxt = plcsv_pkg::S_MAG;
      plcsv_pkg::S_MAG:   state_nxt = plcsv_pkg::S_OUT;
      plcsv_pkg::S_OUT: begin
        if (status.out_free) state_nxt = plcsv_pkg::S_IDLE;
      end
      default: state_nxt = plcsv_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      plcsv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      plcsv_pkg::S_INTEG: cmd.mul_integ = 1'b1;
      plcsv_pkg::S_PROP:  cmd.mul_prop  = 1'b1;
      plcsv_pkg::S_IGAIN: cmd.mul_igain = 1'b1;
      plcsv_pkg::S_DGAIN: cmd.mul_dgain = 1'b1;
      plcsv_pkg::S_SUM:   cmd.sum       = 1'b1;
      plcsv_pkg::S_MAG:   cmd.mag       = 1'b1;
      plcsv_pkg::S_OUT:   cmd.out_load  = status.out_free;
      default: cmd = '0;
    endcase
  end

  // Checks
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == plcsv_pkg::S_INTEG)
    else $error("accepted tick did not start the sequence");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == plcsv_pkg::S_IDLE && !$past(cmd.load))
    else $error("sequence did not return to idle after result load");

endmodule

/* sv/plcsv_dpath.sv */
// Datapath: config registers, PID state, shared multiplier and result register.
module plcsv_dpath #(
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [plcsv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [plcsv_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input payload
  input  logic [plcsv_pkg::SETPOINT_W-1:0]   setpoint,
  input  logic [plcsv_pkg::LEVEL_W-1:0]      level_meas,
  input  logic                               start_request,
  input  logic                               stop_request,
  // control
  input  plcsv_pkg::plcsv_cmd_t              cmd,
  output plcsv_pkg::plcsv_status_t           status,
  // result register
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [plcsv_pkg::CMD_W-1:0]        fill_command,
  output logic [plcsv_pkg::CMD_W-1:0]        discharge_command,
  output logic [plcsv_pkg::DUTY_W-1:0]       fill_duty,
  output logic [plcsv_pkg::DUTY_W-1:0]       discharge_duty,
  output logic                               running
);

  localparam int ACC_W = FRAC_BITS + 38;
  localparam int MAG_W = ACC_W - 2 * FRAC_BITS;
  localparam int PW    = plcsv_pkg::PROD_W;
  localparam int DQ_W  = plcsv_pkg::DIV10_IN_W + plcsv_pkg::DIV10_MUL_W;

  // Configuration registers
  logic [plcsv_pkg::GAIN_W-1:0]   kp_r, ki_r, kd_r;
  logic [plcsv_pkg::PERIOD_W-1:0] period_r;
  logic [plcsv_pkg::LIMIT_W-1:0]  ilim_r, vlim_r;
  logic [plcsv_pkg::DUTY_W-1:0]   dlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= plcsv_pkg::KP_RST;
      ki_r     <= plcsv_pkg::KI_RST;
      kd_r     <= plcsv_pkg::KD_RST;
      period_r <= plcsv_pkg::PERIOD_RST;
      ilim_r   <= plcsv_pkg::ILIM_RST;
      vlim_r   <= plcsv_pkg::VLIM_RST;
      dlim_r   <= plcsv_pkg::DLIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        plcsv_pkg::REG_KP:     kp_r     <= cfg_data;
        plcsv_pkg::REG_KI:     ki_r     <= cfg_data;
        plcsv_pkg::REG_KD:     kd_r     <= cfg_data;
        plcsv_pkg::REG_PERIOD: period_r <= cfg_data[plcsv_pkg::PERIOD_W-1:0];
        plcsv_pkg::REG_ILIM:   ilim_r   <= cfg_data;
        plcsv_pkg::REG_VLIM:   vlim_r   <= cfg_data;
        plcsv_pkg::REG_DLIM:   dlim_r   <= cfg_data[plcsv_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // PID state and per-tick working registers
  logic                                       run_r, run_nxt;
  logic signed [plcsv_pkg::INTEG_W-1:0]       int_sum_r;
  logic signed [plcsv_pkg::ERR_W-1:0]         prev_err_r;
  logic signed [plcsv_pkg::ERR_W-1:0]         err_r, err_nxt;
  logic signed [plcsv_pkg::DIFF_W-1:0]        diff_r;
  logic signed [plcsv_pkg::INTEG_W-1:0]       integ_r, integ_nxt;
  logic signed [PW-1:0]                       prod_r;
  logic signed [ACC_W-1:0]                    acc_r;
  logic        [MAG_W-1:0]                    mag_r;
  logic                                       neg_r;

  // Run flag: stop wins over start
  always_comb begin
    if (stop_request)       run_nxt = 1'b0;
    else if (start_request) run_nxt = 1'b1;
    else                    run_nxt = run_r;
  end

  assign err_nxt = $signed({{(plcsv_pkg::ERR_W-plcsv_pkg::SETPOINT_W){1'b0}}, setpoint})
                 - $signed({1'b0, level_meas});

  // Shared multiplier operand select
  logic signed [plcsv_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0]               mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_integ) begin
      mul_a = plcsv_pkg::MUL_W'(err_r);
      mul_b = $signed({{(plcsv_pkg::MUL_W-plcsv_pkg::PERIOD_W){1'b0}}, period_r});
    end else if (cmd.mul_prop) begin
      mul_a = plcsv_pkg::MUL_W'(err_r);
      mul_b = $signed({{(plcsv_pkg::MUL_W-plcsv_pkg::GAIN_W){1'b0}}, kp_r});
    end else if (cmd.mul_igain) begin
      mul_a = integ_r;
      mul_b = $signed({{(plcsv_pkg::MUL_W-plcsv_pkg::GAIN_W){1'b0}}, ki_r});
    end else if (cmd.mul_dgain) begin
      mul_a = diff_r;
      mul_b = $signed({{(plcsv_pkg::MUL_W-plcsv_pkg::GAIN_W){1'b0}}, kd_r});
    end
  end

  assign mul_p = mul_a * mul_b;

  // Integral update with anti-windup clamp
  logic signed [plcsv_pkg::ISUM_W-1:0] isum, ilim_pos, ilim_neg;

  always_comb begin
    isum     = plcsv_pkg::ISUM_W'(int_sum_r) + prod_r[plcsv_pkg::ISUM_W-1:0];
    ilim_pos = $signed({{(plcsv_pkg::ISUM_W-plcsv_pkg::LIMIT_W){1'b0}}, ilim_r});
    ilim_neg = -ilim_pos;
    if (isum > ilim_pos)      integ_nxt = ilim_pos[plcsv_pkg::INTEG_W-1:0];
    else if (isum < ilim_neg) integ_nxt = ilim_neg[plcsv_pkg::INTEG_W-1:0];
    else                      integ_nxt = isum[plcsv_pkg::INTEG_W-1:0];
  end

  // Product widened to the accumulator, plain and scaled by one
  logic signed [ACC_W-1:0] prod_ext, prod_sc, acc_abs;

  assign prod_ext = ACC_W'(prod_r);
  assign prod_sc  = prod_ext <<< FRAC_BITS;
  assign acc_abs  = acc_r[ACC_W-1] ? -acc_r : acc_r;

  // Working registers and state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      int_sum_r  <= '0;
      prev_err_r <= '0;
    end else begin
      if (cmd.load) run_r <= run_nxt;
      if (cmd.sum) begin
        int_sum_r  <= integ_r;
        prev_err_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) err_r <= err_nxt;
    if (cmd.mul_integ) diff_r <= plcsv_pkg::DIFF_W'(err_r) - plcsv_pkg::DIFF_W'(prev_err_r);
    if (cmd.mul_prop) integ_r <= integ_nxt;
    if (cmd.mul_integ || cmd.mul_prop || cmd.mul_igain || cmd.mul_dgain) prod_r <= mul_p;
    // kp term, then ki term, then kd term
    if (cmd.mul_igain) acc_r <= prod_sc;
    if (cmd.mul_dgain) acc_r <= acc_r + prod_ext;
    if (cmd.sum)       acc_r <= acc_r + prod_sc;
    // magnitude truncated toward zero
    if (cmd.mag) begin
      mag_r <= acc_abs[ACC_W-1:2*FRAC_BITS];
      neg_r <= acc_r[ACC_W-1];
    end
  end

  // Valve saturation and duty divide by ten
  logic [plcsv_pkg::CMD_W-1:0]  cmd_val;
  logic [DQ_W-1:0]              dq;
  logic [plcsv_pkg::DUTY_W-1:0] dq_val, duty_val;

  always_comb begin
    if (mag_r > MAG_W'(vlim_r)) cmd_val = vlim_r;
    else                        cmd_val = mag_r[plcsv_pkg::CMD_W-1:0];
    dq     = DQ_W'(mag_r[plcsv_pkg::DIV10_IN_W-1:0]) * DQ_W'(plcsv_pkg::DIV10_MUL);
    dq_val = dq[plcsv_pkg::DIV10_SHIFT +: plcsv_pkg::DUTY_W];
    if (mag_r >= MAG_W'(plcsv_pkg::DUTY_SAT_MAG)) duty_val = dlim_r;
    else if (dq_val > dlim_r)                     duty_val = dlim_r;
    else                                          duty_val = dq_val;
  end

  // Result register
  logic                         out_valid_r;
  logic [plcsv_pkg::CMD_W-1:0]  fill_r, dis_r;
  logic [plcsv_pkg::DUTY_W-1:0] fduty_r, dduty_r;
  logic                         running_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fill_r    <= (run_r && !neg_r) ? cmd_val  : '0;
      dis_r     <= (run_r &&  neg_r) ? cmd_val  : '0;
      fduty_r   <= (run_r && !neg_r) ? duty_val : '0;
      dduty_r   <= (run_r &&  neg_r) ? duty_val : '0;
      running_r <= run_r;
    end
  end

  assign status.run         = run_r;
  assign status.out_free    = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign fill_command       = fill_r;
  assign discharge_command  = dis_r;
  assign fill_duty          = fduty_r;
  assign discharge_duty     = dduty_r;
  assign running            = running_r;

  // Checks
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result valid without a result load");

  a_one_valve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_r == '0 || dis_r == '0) && (fduty_r == '0 || dduty_r == '0))
    else $error("both valves driven in one result");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !running_r |-> fill_r == '0 && dis_r == '0
                                  && fduty_r == '0 && dduty_r == '0)
    else $error("stopped result carries a valve command");

endmodule

/* sv/pid_level_control_split_valve_top.sv */
// Top level of the split-valve PID tank level controller.
// A running tick passes the integral, proportional, ki, kd, sum, magnitude and
// output states; a stopped tick skips to output, which waits for a free result
// register. One multiplier is shared by the four products in sequence.
// A pending result waits in the output register while the next tick enters.
// Synchronous reset restores register defaults, stops the loop, clears state.
module pid_level_control_split_valve_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [plcsv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plcsv_pkg::CFG_DATA_W-1:0] cfg_data,
  plcsv_in_if.sink                         in_chan,
  plcsv_out_if.source                      out_chan
);

  plcsv_pkg::plcsv_cmd_t    cmd;
  plcsv_pkg::plcsv_status_t status;
  logic                     in_ready;

  assign in_chan.ready = in_ready;

  // Sequencer
  plcsv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and result register
  plcsv_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .setpoint          (in_chan.setpoint),
    .level_meas        (in_chan.level_meas),
    .start_request     (in_chan.start_request),
    .stop_request      (in_chan.stop_request),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .fill_command      (out_chan.fill_command),
    .discharge_command (out_chan.discharge_command),
    .fill_duty         (out_chan.fill_duty),
    .discharge_duty    (out_chan.discharge_duty),
    .running           (out_chan.running)
  );

endmodule
